// ===== src/rme_pkg.sv =====
// Shared constants and codes for the modular exponentiation block.
package rme_pkg;
	localparam int NUM_WORDS = 16;
	localparam int WORD_W    = 64;
	localparam int IDX_W     = 4;
	localparam int NUM_W     = NUM_WORDS * WORD_W;
	localparam int REM_W     = NUM_W + 2;
	localparam int BIT_CNT_W = $clog2(NUM_W);

	localparam logic [1:0] OP_LOAD_BASE = 2'd0;
	localparam logic [1:0] OP_LOAD_EXP  = 2'd1;
	localparam logic [1:0] OP_LOAD_MOD  = 2'd2;
	localparam logic [1:0] OP_START     = 2'd3;
endpackage

// ===== src/rme_cmd_if.sv =====
// Command channel: operand word loads and start.
interface rme_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  word_index;
	logic [63:0] word_value;
	modport source (output valid, op, word_index, word_value, input ready);
	modport sink   (input valid, op, word_index, word_value, output ready);
endinterface

// ===== src/rme_rsp_if.sv =====
// Result channel: one result word per item.
interface rme_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  result_index;
	logic [63:0] result_word;
	logic        last;
	logic        error;
	modport source (output valid, result_index, result_word, last, error, input ready);
	modport sink   (input valid, result_index, result_word, last, error, output ready);
endinterface

// ===== src/rme_addsub.sv =====
// Shared wide adder/subtractor used by every modular step.
module rme_addsub
	import rme_pkg::*;
(
	input  logic [REM_W-1:0] x,
	input  logic [REM_W-1:0] y,
	input  logic             sub,
	output logic [REM_W-1:0] sum,
	output logic             carry
);
	logic [REM_W:0] full;

	// subtract as x + ~y + 1; carry out set means x >= y
	assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{REM_W{1'b0}}, sub};
	assign sum   = full[REM_W-1:0];
	assign carry = full[REM_W];
endmodule

// ===== src/rsa_modular_exponentiation.sv =====
// Top level: 1024-bit modular exponentiation with a shared add/subtract unit.
//
// Load items (op 0..2) write one 64-bit word of base, exponent or modulus.
// A start item computes base^exponent mod modulus and then emits 16 result
// items, word 0 first, last set on word 15. All arithmetic runs through one
// 1026-bit adder/subtractor: each modular multiply is an interleaved
// shift-add-reduce over the 1024 multiplier bits, each bit taking a double
// and add, then two conditional subtracts of the modulus. The base is first
// reduced the same way, then the exponent is scanned from bit 0 up to its
// top set bit with one squaring per bit below the top set bit and one extra
// multiply per set bit: a full-length exponent costs up to about 2047
// multiplies. A zero modulus skips the work and returns zero words with
// error set. The command side is not ready from start until the last result
// word has been taken.
module rsa_modular_exponentiation
	import rme_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rme_cmd_if.sink   cmd,
	rme_rsp_if.source rsp
);
	typedef enum logic [2:0] {
		S_IDLE, S_ADD, S_SUB1, S_SUB2, S_FIN, S_STEP, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		JOB_BASE, JOB_ACC, JOB_SQ
	} job_t;

	state_t               state_q;
	job_t                 job_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 err_q;

	logic [NUM_W-1:0] base_q, exp_q, mod_q;
	logic [NUM_W-1:0] acc_q, sq_q;
	logic [NUM_W-1:0] mul_a_q;   // multiplier, consumed MSB first
	logic [NUM_W-1:0] e_q;       // remaining exponent bits
	logic [REM_W-1:0] rem_q;     // partial remainder

	logic [REM_W-1:0] u_x, u_y, u_sum;
	logic             u_sub, u_carry;
	logic [REM_W-1:0] addend;

	rme_addsub u_addsub (
		.x     (u_x),
		.y     (u_y),
		.sub   (u_sub),
		.sum   (u_sum),
		.carry (u_carry)
	);

	// base reduction shifts in raw bits; a multiply adds the multiplicand
	always_comb begin
		if (job_q == JOB_BASE) begin
			addend = {{(REM_W-1){1'b0}}, mul_a_q[NUM_W-1]};
		end else begin
			addend = mul_a_q[NUM_W-1] ? {2'b00, sq_q} : '0;
		end
	end

	always_comb begin
		if (state_q == S_ADD) begin
			u_x   = {rem_q[REM_W-2:0], 1'b0};
			u_y   = addend;
			u_sub = 1'b0;
		end else begin
			u_x   = rem_q;
			u_y   = {2'b00, mod_q};
			u_sub = 1'b1;
		end
	end

	assign cmd.ready        = (state_q == S_IDLE);
	assign rsp.valid        = (state_q == S_OUT);
	assign rsp.result_index = out_idx_q;
	assign rsp.result_word  = acc_q[out_idx_q*WORD_W +: WORD_W];
	assign rsp.last         = (out_idx_q == IDX_W'(NUM_WORDS - 1));
	assign rsp.error        = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= JOB_BASE;
			cnt_q     <= '0;
			out_idx_q <= '0;
			err_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd.op)
							OP_LOAD_BASE: base_q[cmd.word_index*WORD_W +: WORD_W] <= cmd.word_value;
							OP_LOAD_EXP:  exp_q[cmd.word_index*WORD_W +: WORD_W]  <= cmd.word_value;
							OP_LOAD_MOD:  mod_q[cmd.word_index*WORD_W +: WORD_W]  <= cmd.word_value;
							OP_START: begin
								out_idx_q <= '0;
								if (mod_q == '0) begin
									acc_q   <= '0;
									err_q   <= 1'b1;
									state_q <= S_OUT;
								end else begin
									// 1 mod m is 0 only for m = 1
									acc_q   <= (mod_q == NUM_W'(1)) ? '0 : NUM_W'(1);
									err_q   <= 1'b0;
									mul_a_q <= base_q;
									rem_q   <= '0;
									job_q   <= JOB_BASE;
									cnt_q   <= BIT_CNT_W'(NUM_W - 1);
									state_q <= S_ADD;
								end
							end
							default: ;
						endcase
					end
				end
				S_ADD: begin
					rem_q   <= u_sum;
					mul_a_q <= {mul_a_q[NUM_W-2:0], 1'b0};
					state_q <= S_SUB1;
				end
				S_SUB1: begin
					if (u_carry) rem_q <= u_sum;
					state_q <= S_SUB2;
				end
				S_SUB2: begin
					if (u_carry) rem_q <= u_sum;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_ADD;
					end
				end
				S_FIN: begin
					rem_q <= '0;
					cnt_q <= BIT_CNT_W'(NUM_W - 1);
					unique case (job_q)
						JOB_BASE: begin
							sq_q    <= rem_q[NUM_W-1:0];
							e_q     <= exp_q;
							state_q <= S_STEP;
						end
						JOB_ACC: begin
							acc_q <= rem_q[NUM_W-1:0];
							// no squaring after the top set bit
							if ((e_q >> 1) == '0) begin
								state_q <= S_OUT;
							end else begin
								mul_a_q <= sq_q;
								job_q   <= JOB_SQ;
								state_q <= S_ADD;
							end
						end
						default: begin
							sq_q    <= rem_q[NUM_W-1:0];
							e_q     <= e_q >> 1;
							state_q <= S_STEP;
						end
					endcase
				end
				S_STEP: begin
					if (e_q == '0) begin
						state_q <= S_OUT;
					end else if (e_q[0]) begin
						mul_a_q <= acc_q;
						job_q   <= JOB_ACC;
						state_q <= S_ADD;
					end else begin
						mul_a_q <= sq_q;
						job_q   <= JOB_SQ;
						state_q <= S_ADD;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						if (out_idx_q == IDX_W'(NUM_WORDS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// never take a command while results are being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !cmd.ready)
		else $error("command accepted during result delivery");

	// a zero-modulus result is all zero words
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.error) |-> (rsp.result_word == '0))
		else $error("error result with nonzero word");

	// after the last word is taken the block is ready again
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.last) |=> cmd.ready)
		else $error("not ready after last result word");

	// remainder is below the modulus once a multiply finishes, so its top two bits are clear in S_FIN
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (rem_q[REM_W-1:NUM_W] == '0))
		else $error("partial remainder out of range");
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the 1024-bit modular exponentiation block.
module testbench
	import rme_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [63:0] val;
	} cmd_item_t;

	typedef struct {
		logic [3:0]  idx;
		logic [63:0] word;
		logic        last;
		logic        err;
	} word_item_t;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int HOLD_CYCLES    = 400;

	logic clk;
	logic arst_n;

	rme_cmd_if cmd ();
	rme_rsp_if rsp ();

	rsa_modular_exponentiation uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	// pending command items, and result words still owed by the block
	cmd_item_t  cmd_queue[$];
	word_item_t owed_words[$];

	// shadow copies of the operand stores
	logic [63:0] base_words[NUM_WORDS];
	logic [63:0] exp_words[NUM_WORDS];
	logic [63:0] mod_words[NUM_WORDS];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  mismatches;
	int  quiet_cycles;
	int  hold_left;
	bit  hold_req;
	bit  cmd_took;

	// 2048-bit value reduced modulo m by shift and conditional subtract
	function automatic logic [NUM_W-1:0] reduce_wide(input logic [2*NUM_W-1:0] p,
		input logic [NUM_W-1:0] m);
		logic [NUM_W:0] r;
		r = '0;
		for (int i = 2*NUM_W-1; i >= 0; i--) begin
			r = {r[NUM_W-1:0], p[i]};
			if (r >= {1'b0, m})
				r = r - {1'b0, m};
		end
		return r[NUM_W-1:0];
	endfunction

	function automatic logic [NUM_W-1:0] mul_mod(input logic [NUM_W-1:0] a,
		input logic [NUM_W-1:0] b, input logic [NUM_W-1:0] m);
		logic [2*NUM_W-1:0] p;
		p = {{NUM_W{1'b0}}, a} * {{NUM_W{1'b0}}, b};
		return reduce_wide(p, m);
	endfunction

	// apply one accepted command item; a start queues the 16 words it owes
	task automatic apply_cmd(input cmd_item_t c);
		logic [NUM_W-1:0] m, e, sq, acc;
		int               top;
		word_item_t       w;
		if (c.op != OP_START) begin
			case (c.op)
				OP_LOAD_BASE: base_words[c.idx] = c.val;
				OP_LOAD_EXP:  exp_words[c.idx]  = c.val;
				default:      mod_words[c.idx]  = c.val;
			endcase
			return;
		end
		for (int k = 0; k < NUM_WORDS; k++) begin
			m[k*WORD_W +: WORD_W]  = mod_words[k];
			e[k*WORD_W +: WORD_W]  = exp_words[k];
			sq[k*WORD_W +: WORD_W] = base_words[k];
		end
		acc = '0;
		if (m != '0) begin
			acc = reduce_wide({{(2*NUM_W-1){1'b0}}, 1'b1}, m);
			sq  = reduce_wide({{NUM_W{1'b0}}, sq}, m);
			top = -1;
			for (int i = 0; i < NUM_W; i++)
				if (e[i])
					top = i;
			for (int i = 0; i <= top; i++) begin
				if (e[i])
					acc = mul_mod(acc, sq, m);
				if (i < top)
					sq = mul_mod(sq, sq, m);
			end
		end
		for (int k = 0; k < NUM_WORDS; k++) begin
			w.idx  = k[3:0];
			w.word = acc[k*WORD_W +: WORD_W];
			w.last = (k == NUM_WORDS - 1);
			w.err  = (m == '0);
			owed_words.push_back(w);
		end
	endtask

	task automatic push_cmd(input logic [1:0] op, input logic [3:0] idx,
		input logic [63:0] val);
		cmd_item_t c;
		c.op  = op;
		c.idx = idx;
		c.val = val;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random-content exponentiation: a few word loads then a start.
	// Exponents stay within six bits so that a start costs at most eleven
	// multiplies; higher exponent words are only ever written with zero.
	task automatic push_random_job();
		int n;
		n = $urandom_range(2, 8);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: push_cmd(OP_LOAD_BASE, 4'($urandom_range(0, 15)), rand64());
				1: begin
					if ($urandom_range(0, 2) == 0)
						push_cmd(OP_LOAD_EXP, 4'($urandom_range(1, 15)), 64'd0);
					else
						push_cmd(OP_LOAD_EXP, 4'd0, 64'($urandom_range(0, 63)));
				end
				default: begin
					if ($urandom_range(0, 4) == 0)
						push_cmd(OP_LOAD_MOD, 4'($urandom_range(0, 14)), 64'd0);
					else
						push_cmd(OP_LOAD_MOD, 4'($urandom_range(0, 15)), rand64());
				end
			endcase
		end
		// the index and value of a start are don't-care: drive noise there
		push_cmd(OP_START, 4'($urandom_range(0, 15)), rand64());
	endtask

	task automatic drain();
		while (cmd_queue.size() != 0 || cmd.valid || owed_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command driver: accept at the rising edge, present the next item at the falling one
	always @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_item_t c;
			c.op  = cmd.op;
			c.idx = cmd.word_index;
			c.val = cmd.word_value;
			apply_cmd(c);
			cmd_took = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (cmd_took || !cmd.valid)) begin
			if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd_item_t c;
				c = cmd_queue.pop_front();
				cmd.valid      <= 1'b1;
				cmd.op         <= c.op;
				cmd.word_index <= c.idx;
				cmd.word_value <= c.val;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
		cmd_took = 1'b0;
	end

	// result receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && rsp.valid) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			word_item_t want;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: idx %0d word %h last %b err %b",
						rsp.result_index, rsp.result_word, rsp.last, rsp.error);
			end else begin
				want = owed_words.pop_front();
				if (rsp.result_index !== want.idx || rsp.result_word !== want.word ||
					rsp.last !== want.last || rsp.error !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: exp idx %0d word %h last %b err %b, ",
							"got idx %0d word %h last %b err %b"},
							want.idx, want.word, want.last, want.err,
							rsp.result_index, rsp.result_word, rsp.last, rsp.error);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cmd.valid      = 1'b0;
		cmd.op         = OP_LOAD_BASE;
		cmd.word_index = '0;
		cmd.word_value = '0;
		rsp.ready      = 1'b0;
		send_idle_pct  = 19;
		recv_idle_pct  = 75;
		mismatches     = 0;
		quiet_cycles   = 0;
		hold_left      = 0;
		hold_req       = 1'b0;
		cmd_took       = 1'b0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			base_words[k] = '0;
			exp_words[k]  = '0;
			mod_words[k]  = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n = 1'b1;

		// Directed part. Every store word is written before the first start,
		// so that nothing undefined is ever read.
		for (int k = 0; k < NUM_WORDS; k++) begin
			push_cmd(OP_LOAD_BASE, 4'(k), (k % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : '1);
			push_cmd(OP_LOAD_MOD, 4'(k), '1);
			push_cmd(OP_LOAD_EXP, 4'(k), '0);
		end
		push_cmd(OP_START, 4'hF, '1);        // exponent zero gives one
		push_cmd(OP_LOAD_EXP, 4'd0, 64'd1);
		push_cmd(OP_START, 4'h0, '0);        // base reduced by an all-ones modulus
		push_cmd(OP_LOAD_EXP, 4'd0, 64'd63);
		push_cmd(OP_LOAD_BASE, 4'd15, '0);
		push_cmd(OP_LOAD_MOD, 4'd0, 64'h5555_5555_5555_5555);
		push_cmd(OP_START, 4'h5, 64'h5555_5555_5555_5555);
		// zero modulus: error flag and zero words
		for (int k = 0; k < NUM_WORDS; k++)
			push_cmd(OP_LOAD_MOD, 4'(k), '0);
		push_cmd(OP_START, 4'hA, '0);
		// modulus of one: everything reduces to zero
		push_cmd(OP_LOAD_MOD, 4'd0, 64'd1);
		push_cmd(OP_START, 4'h3, '0);
		push_cmd(OP_LOAD_EXP, 4'd0, 64'd0);
		push_cmd(OP_START, 4'h3, '0);        // exponent zero under modulus one
		// restore a full-width modulus for the random part
		for (int k = 0; k < NUM_WORDS; k++)
			push_cmd(OP_LOAD_MOD, 4'(k), rand64() | ((k == 15) ? 64'h8000_0000_0000_0000 : 64'd0));
		push_cmd(OP_LOAD_EXP, 4'd0, 64'd37);
		push_cmd(OP_START, 4'h0, '0);
		drain();

		// random part, sender mostly busy and receiver mostly stalling
		repeat (1) push_random_job();
		drain();

		// other way round; the long receiver hold-off falls here
		send_idle_pct = 75;
		recv_idle_pct = 19;
		hold_req      = 1'b1;
		repeat (1) push_random_job();
		drain();

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (1) push_random_job();
		drain();
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
